@@ sv/one_button_dimmer_assert.svh @@
// Assertion macros shared by the dimmer RTL.
`ifndef ONE_BUTTON_DIMMER_ASSERT_SVH
`define ONE_BUTTON_DIMMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/obd_pkg.sv @@
package obd_pkg;

    localparam int TICK_W  = 16;
    localparam int LEVEL_W = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SWITCH = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_PRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX    = 3'd4;

    localparam logic [TICK_W-1:0]  RST_LONG_PRESS   = 16'd2000;
    localparam logic [TICK_W-1:0]  RST_DOUBLE_PRESS = 16'd1000;
    localparam logic [TICK_W-1:0]  RST_RAMP_PERIOD  = 16'd150;
    localparam logic [LEVEL_W-1:0] RST_RAMP_STEP    = 7'd3;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_MAX    = 7'd100;

    typedef struct packed {
        logic [1:0]         mode;
        logic               switch_level;
        logic [LEVEL_W-1:0] level_in;
    } t_in_item;

    typedef struct packed {
        logic               pressed;
        logic               double_pressed;
        logic               long_pressed;
        logic               level_changed;
        logic [LEVEL_W-1:0] level;
        logic               held;
    } t_out_item;

endpackage

@@ sv/one_button_dimmer.sv @@
// One-button dimmer: classifies a push button and ramps a dim level.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): each transfer is a
// one-millisecond tick, a switch contact level, or a direct level write.
// Output channel (o_out_valid / i_out_stall, payload o_out): exactly one
// result per input transfer, in order, with the press / double press /
// long press / level-changed flags, the level and the held state.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 long press, 1 double-press window, 2 ramp period, 3 ramp step,
// 4 level max); other indexes are dropped. Write only while idle.
//
// Throughput: one item per clock unless o_in_stall is high; all state is
// updated in the accepting cycle by one add-and-compare per timer and one
// 8-bit add for the ramp. A skid register behind the output register lets
// the block take an item while a result still waits; o_in_stall rises only
// when both are full. Reset (i_rst_n low, synchronous) loads default
// timings, releases the button, zeroes the level and timers, and empties
// the output side.
module one_button_dimmer #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  obd_pkg::t_in_item           i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output obd_pkg::t_out_item          o_out,
    input  logic                        i_cfg_we,
    input  logic [obd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [obd_pkg::CFG_W-1:0]   i_cfg_data
);
    import obd_pkg::*;

    `include "one_button_dimmer_assert.svh"

    // compare width covers both the counters and the 16-bit registers
    localparam int CW = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_TOP = '1;

    // configuration
    logic [TICK_W-1:0]  r_long_ticks, r_double_ticks, r_period_ticks;
    logic [LEVEL_W-1:0] r_step, r_level_max;

    // button and ramp state
    logic                   r_held, n_held;
    logic [LEVEL_W-1:0]     r_level, n_level;
    logic                   r_ramp_up, n_ramp_up;
    logic [TIMER_WIDTH-1:0] r_ramp_count, n_ramp_count;
    logic [TIMER_WIDTH-1:0] r_long_count, n_long_count;
    logic                   r_long_armed, n_long_armed;
    logic [TIMER_WIDTH-1:0] r_win_count, n_win_count;
    logic                   r_win_open, n_win_open;

    // output register and skid stage
    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;
    t_out_item w_result;

    logic w_accept, w_taken;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_taken     = r_out_valid && !i_out_stall;

    // saturating increments
    logic [TIMER_WIDTH-1:0] w_ramp_inc, w_long_inc, w_win_inc;
    assign w_ramp_inc = (r_ramp_count < TIMER_TOP) ? r_ramp_count + 1'b1 : r_ramp_count;
    assign w_long_inc = (r_long_count < TIMER_TOP) ? r_long_count + 1'b1 : r_long_count;
    assign w_win_inc  = (r_win_count  < TIMER_TOP) ? r_win_count  + 1'b1 : r_win_count;

    logic w_ramp_fire, w_long_fire, w_win_fire;
    assign w_ramp_fire = CW'(w_ramp_inc) >= CW'(r_period_ticks);
    assign w_long_fire = CW'(w_long_inc) >= CW'(r_long_ticks);
    assign w_win_fire  = CW'(w_win_inc)  >= CW'(r_double_ticks);

    // one triangle-wave ramp step
    logic [LEVEL_W:0]   w_level_sum;
    logic [LEVEL_W-1:0] w_step_level;
    logic               w_step_up;
    assign w_level_sum = {1'b0, r_level} + {1'b0, r_step};

    always_comb begin
        if (r_ramp_up) begin
            if (w_level_sum >= {1'b0, r_level_max}) begin
                w_step_level = r_level_max;
                w_step_up    = 1'b0;
            end else begin
                w_step_level = w_level_sum[LEVEL_W-1:0];
                w_step_up    = 1'b1;
            end
        end else begin
            if (r_level <= r_step) begin
                w_step_level = '0;
                w_step_up    = 1'b1;
            end else begin
                w_step_level = r_level - r_step;
                w_step_up    = 1'b0;
            end
        end
    end

    // next state and result for the item on the input port
    always_comb begin
        n_held       = r_held;
        n_level      = r_level;
        n_ramp_up    = r_ramp_up;
        n_ramp_count = r_ramp_count;
        n_long_count = r_long_count;
        n_long_armed = r_long_armed;
        n_win_count  = r_win_count;
        n_win_open   = r_win_open;
        w_result     = '0;

        unique case (i_in.mode)
            MODE_TICK: begin
                if (r_held) begin
                    n_ramp_count = w_ramp_inc;
                    if (w_ramp_fire) begin
                        n_ramp_count           = '0;
                        n_level                = w_step_level;
                        n_ramp_up              = w_step_up;
                        w_result.level_changed = 1'b1;
                    end
                end
                if (r_long_armed) begin
                    n_long_count = w_long_inc;
                    if (w_long_fire) begin
                        n_long_armed          = 1'b0;
                        w_result.long_pressed = 1'b1;
                    end
                end
                if (r_win_open) begin
                    n_win_count = w_win_inc;
                    if (w_win_fire) begin
                        n_win_open = 1'b0;
                    end
                end
            end
            MODE_SWITCH: begin
                if (i_in.switch_level != r_held) begin
                    n_held = i_in.switch_level;
                    if (i_in.switch_level) begin
                        n_ramp_count = '0;
                        n_long_count = '0;
                        n_long_armed = 1'b1;
                        if (r_win_open) begin
                            n_win_open              = 1'b0;
                            w_result.double_pressed = 1'b1;
                        end else begin
                            n_win_open       = 1'b1;
                            n_win_count      = '0;
                            w_result.pressed = 1'b1;
                        end
                    end else begin
                        n_long_armed = 1'b0;
                    end
                end
            end
            MODE_WRITE: begin
                n_level = (i_in.level_in > r_level_max) ? r_level_max : i_in.level_in;
                w_result.level_changed = 1'b1;
            end
            default: begin
                // unused mode: report state, change nothing
            end
        endcase

        w_result.level = n_level;
        w_result.held  = n_held;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= RST_LONG_PRESS;
            r_double_ticks <= RST_DOUBLE_PRESS;
            r_period_ticks <= RST_RAMP_PERIOD;
            r_step         <= RST_RAMP_STEP;
            r_level_max    <= RST_LEVEL_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LONG_PRESS:   r_long_ticks   <= i_cfg_data;
                REG_DOUBLE_PRESS: r_double_ticks <= i_cfg_data;
                REG_RAMP_PERIOD:  r_period_ticks <= i_cfg_data;
                REG_RAMP_STEP:    r_step         <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_MAX:    r_level_max    <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the button state on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b0;
            r_level      <= '0;
            r_ramp_up    <= 1'b1;
            r_ramp_count <= '0;
            r_long_count <= '0;
            r_long_armed <= 1'b0;
            r_win_count  <= '0;
            r_win_open   <= 1'b0;
        end else if (w_accept) begin
            r_held       <= n_held;
            r_level      <= n_level;
            r_ramp_up    <= n_ramp_up;
            r_ramp_count <= n_ramp_count;
            r_long_count <= n_long_count;
            r_long_armed <= n_long_armed;
            r_win_count  <= n_win_count;
            r_win_open   <= n_win_open;
        end
    end

    // output register with skid: load the result straight out when the
    // output slot frees up, else park it in the skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_taken) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (!r_out_valid || w_taken) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_taken) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_taken) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    `OBD_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid stage holds a result while the output register is empty")
    `OBD_ASSERT_NEXT(a_accept_gives_out, i_clk, i_rst_n, w_accept, r_out_valid,
        "accepted item produced no result")
    `OBD_ASSERT_NEXT(a_full_stalls, i_clk, i_rst_n,
        w_accept && r_out_valid && i_out_stall, o_in_stall,
        "output side full but input not stalled")
    `OBD_ASSERT_SAME(a_armed_needs_held, i_clk, i_rst_n, r_long_armed, r_held,
        "long-press timer armed while button released")

endmodule
